/* rtl/xae_pkg.sv */
// Shared types, character codes and entity tables for the XML attribute escaper.
package xae_pkg;

    localparam int CP_W        = 21;
    localparam int CH_W        = 7;
    localparam int QUEUE_DEPTH = 4;

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT holds for every x below 2**22.
    localparam int DIV10_MUL_W = 20;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 20'd838861;
    localparam int DIV10_SHIFT = 23;
    localparam int PROD_W      = CP_W + DIV10_MUL_W;
    localparam int QUOT_W      = PROD_W - DIV10_SHIFT;

    // A 21-bit value has at most seven decimal digits.
    localparam int MAX_DIGITS  = 7;
    localparam int DIGIT_IDX_W = 3;

    localparam logic [CH_W-1:0] CH_QUOT  = 7'h22;
    localparam logic [CH_W-1:0] CH_HASH  = 7'h23;
    localparam logic [CH_W-1:0] CH_AMP   = 7'h26;
    localparam logic [CH_W-1:0] CH_APOS  = 7'h27;
    localparam logic [CH_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CH_W-1:0] CH_SEMI  = 7'h3B;
    localparam logic [CH_W-1:0] CH_LT    = 7'h3C;
    localparam logic [CP_W-1:0] PRINT_LO = 21'd32;
    localparam logic [CP_W-1:0] PRINT_HI = 21'd126;

    localparam logic [3:0][7:0] TXT_LT   = "&lt;";
    localparam logic [4:0][7:0] TXT_AMP  = "&amp;";
    localparam logic [5:0][7:0] TXT_QUOT = "&quot;";
    localparam logic [5:0][7:0] TXT_APOS = "&apos;";

    typedef enum logic [2:0] {
        K_PLAIN,
        K_LT,
        K_AMP,
        K_QUOT,
        K_APOS,
        K_NUM
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [CP_W-1:0]  cp;
    } qentry_t;

    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qhead_t;

    // Index of the final byte of a named entity.
    function automatic logic [2:0] ent_last_idx(input kind_t kind);
        logic [2:0] n;
        case (kind)
            K_LT:    n = 3'd3;
            K_AMP:   n = 3'd4;
            K_QUOT:  n = 3'd5;
            K_APOS:  n = 3'd5;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [CH_W-1:0] ent_char(input kind_t kind, input logic [2:0] idx);
        logic [7:0] b;
        case (kind)
            K_LT:    b = TXT_LT[2'(3'd3 - idx)];
            K_AMP:   b = TXT_AMP[3'(3'd4 - idx)];
            K_QUOT:  b = TXT_QUOT[3'(3'd5 - idx)];
            K_APOS:  b = TXT_APOS[3'(3'd5 - idx)];
            default: b = 8'h00;
        endcase
        return b[CH_W-1:0];
    endfunction

endpackage

/* rtl/xae_front.sv */
// Front end: delimiter register and classification of incoming code points.
module xae_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,
    input  logic [xae_pkg::CP_W-1:0]  code_point,
    output xae_pkg::qentry_t          entry
);

    logic quote_mode_reg;
    logic quote_mode_next;

    always_comb
    begin
        quote_mode_next = cfg_wr_en ? cfg_wr_data : quote_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_mode_reg <= 1'b0;
        end
        else
        begin
            quote_mode_reg <= quote_mode_next;
        end
    end

    always_comb
    begin
        entry.cp = code_point;
        if (code_point == xae_pkg::CP_W'(xae_pkg::CH_LT))
        begin
            entry.kind = xae_pkg::K_LT;
        end
        else if (code_point == xae_pkg::CP_W'(xae_pkg::CH_AMP))
        begin
            entry.kind = xae_pkg::K_AMP;
        end
        else if (code_point == xae_pkg::CP_W'(xae_pkg::CH_QUOT) && !quote_mode_reg)
        begin
            entry.kind = xae_pkg::K_QUOT;
        end
        else if (code_point == xae_pkg::CP_W'(xae_pkg::CH_APOS) && quote_mode_reg)
        begin
            entry.kind = xae_pkg::K_APOS;
        end
        else if (code_point inside {[xae_pkg::PRINT_LO:xae_pkg::PRINT_HI]})
        begin
            entry.kind = xae_pkg::K_PLAIN;
        end
        else
        begin
            entry.kind = xae_pkg::K_NUM;
        end
    end

endmodule

/* rtl/xae_queue.sv */
// Small request queue between the classifier and the byte sequencer.
module xae_queue #(
    parameter int DEPTH = xae_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  xae_pkg::qentry_t push_entry,
    output logic             full,
    input  logic             pop,
    output xae_pkg::qhead_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xae_pkg::qentry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/xae_back.sv */
// Back end: turns queued requests into escaped bytes, one byte per output cycle while the output is not stalled.
module xae_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  xae_pkg::qhead_t           head,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [xae_pkg::CH_W-1:0]  out_char,
    output logic                      last
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_CONV,
        B_EMIT
    } bstate_t;

    bstate_t                              state_reg;
    bstate_t                              state_next;
    logic [3:0]                           idx_reg;
    logic [3:0]                           idx_next;
    logic [xae_pkg::CP_W-1:0]             value_reg;
    logic [xae_pkg::CP_W-1:0]             value_next;
    logic [xae_pkg::DIGIT_IDX_W-1:0]      nd_reg;
    logic [xae_pkg::DIGIT_IDX_W-1:0]      nd_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic [xae_pkg::CH_W-1:0]             out_char_reg;
    logic [xae_pkg::CH_W-1:0]             out_char_next;
    logic                                 last_reg;
    logic                                 last_next;

    logic [3:0]                           digits [xae_pkg::MAX_DIGITS];

    logic                                 out_free;
    logic                                 emit;
    logic [xae_pkg::CH_W-1:0]             emit_char;
    logic                                 emit_last;
    logic                                 dig_we;
    logic [xae_pkg::PROD_W-1:0]           prod;
    logic [xae_pkg::QUOT_W-1:0]           quot;
    logic [3:0]                           quot_x10;
    logic [3:0]                           digit;
    logic [xae_pkg::DIGIT_IDX_W-1:0]      dsel;
    logic [3:0]                           emit_end;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Divide by ten through a reciprocal multiply; the remainder only needs the low nibble.
    assign prod     = xae_pkg::PROD_W'(value_reg) * xae_pkg::PROD_W'(xae_pkg::DIV10_MUL);
    assign quot     = prod[xae_pkg::PROD_W-1:xae_pkg::DIV10_SHIFT];
    assign quot_x10 = 4'({quot[0], 3'b000} + {quot[2:0], 1'b0});
    assign digit    = value_reg[3:0] - quot_x10;

    // Digits are stored least significant first, so they are read back in reverse.
    assign dsel     = xae_pkg::DIGIT_IDX_W'(({1'b0, nd_reg} + 4'd1) - idx_reg);
    assign emit_end = {1'b0, nd_reg} + 4'd2;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        value_next = value_reg;
        nd_next    = nd_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_char  = '0;
        emit_last  = 1'b0;
        dig_we     = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    case (head.entry.kind)
                        xae_pkg::K_PLAIN:
                        begin
                            if (out_free)
                            begin
                                emit      = 1'b1;
                                emit_char = head.entry.cp[xae_pkg::CH_W-1:0];
                                emit_last = 1'b1;
                                pop       = 1'b1;
                            end
                        end
                        xae_pkg::K_NUM:
                        begin
                            value_next = head.entry.cp;
                            nd_next    = '0;
                            state_next = B_CONV;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                emit      = 1'b1;
                                emit_char = xae_pkg::ent_char(head.entry.kind, idx_reg[2:0]);
                                if (idx_reg[2:0] == xae_pkg::ent_last_idx(head.entry.kind))
                                begin
                                    emit_last = 1'b1;
                                    pop       = 1'b1;
                                    idx_next  = '0;
                                end
                                else
                                begin
                                    idx_next = idx_reg + 4'd1;
                                end
                            end
                        end
                    endcase
                end
            end
            B_CONV:
            begin
                dig_we     = 1'b1;
                nd_next    = nd_reg + 1'b1;
                value_next = xae_pkg::CP_W'(quot);
                if (quot == '0)
                begin
                    state_next = B_EMIT;
                    idx_next   = '0;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (idx_reg == 4'd0)
                    begin
                        emit_char = xae_pkg::CH_AMP;
                    end
                    else if (idx_reg == 4'd1)
                    begin
                        emit_char = xae_pkg::CH_HASH;
                    end
                    else if (idx_reg == emit_end)
                    begin
                        emit_char  = xae_pkg::CH_SEMI;
                        emit_last  = 1'b1;
                        pop        = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        emit_char = xae_pkg::CH_ZERO + xae_pkg::CH_W'(digits[dsel]);
                    end
                    idx_next = (idx_reg == emit_end) ? 4'd0 : idx_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
                idx_next   = '0;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            last_next      = emit_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            value_reg     <= '0;
            nd_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            value_reg     <= value_next;
            nd_reg        <= nd_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dig_we)
        begin
            digits[nd_reg] <= digit;
        end
    end

endmodule

/* rtl/xml_attribute_escape.sv */
// Top level of the XML attribute value escaper.
//
// Each accepted code point produces its escaped byte run on the output, with last set on the
// final byte. Printable characters that need no escape go through at one per cycle while
// the output is not stalled. A named entity (&lt; &amp; &quot; &apos;) is sent as 4 to 6
// bytes. A decimal reference for a value with D digits (D from 1 to 7) first loads the value,
// then runs the divide-by-ten unit, which produces one digit per cycle, and then sends D + 3
// bytes; that unit and the single output register set the pace for escapes. A request queue
// of QUEUE_DEPTH entries sits between the classifier and the byte sequencer, so input is
// taken while a run is still being sent. The quote_mode register (written through cfg_wr_en
// and cfg_wr_data, reset to double quote) selects which quote character is escaped; write it
// only while the block is idle.
module xml_attribute_escape #(
    parameter int QUEUE_DEPTH = xae_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [xae_pkg::CP_W-1:0]  code_point,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [xae_pkg::CH_W-1:0]  out_char,
    output logic                      last
);

    xae_pkg::qentry_t front_entry;
    xae_pkg::qhead_t  q_head;
    logic             q_full;
    logic             q_pop;
    logic             q_push;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    xae_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .code_point  (code_point),
        .entry       (front_entry)
    );

    xae_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head)
    );

    xae_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last)
    );

    // A semicolon only ever closes a run.
    a_semi_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_char == xae_pkg::CH_SEMI |-> last)
        else $error("semicolon sent in the middle of a run");

    // An ampersand or less-than sign can never be a run on its own.
    a_no_bare_special: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> out_char != xae_pkg::CH_AMP && out_char != xae_pkg::CH_LT)
        else $error("unescaped special character sent");

    // The sequencer only releases a request that the queue actually holds.
    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("request released from an empty queue");

    // A released request always coincides with the final byte of its run being loaded.
    a_pop_sends_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid && last)
        else $error("request released without its final byte");

endmodule

/* tb/tb.sv */
// Testbench for the XML attribute value escaper: directed and random code points, checked byte by byte.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [xae_pkg::CH_W-1:0] ch;
        logic                     fin;
    } esc_byte_t;

    logic                     clk;
    logic                     rst_n       = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic                     cfg_wr_data = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic [xae_pkg::CP_W-1:0] code_point  = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic [xae_pkg::CH_W-1:0] out_char;
    logic                     last;

    esc_byte_t   expected_bytes[$];
    logic        model_quote_mode = 1'b0;
    int          send_idle_pct    = 0;
    int          recv_idle_pct    = 0;
    int          errors           = 0;
    int unsigned cycle_count      = 0;

    xml_attribute_escape dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .code_point (code_point),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last       (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void push_text(input string s);
        esc_byte_t b;
        for (int i = 0; i < s.len(); i++)
        begin
            b.ch  = xae_pkg::CH_W'(s[i]);
            b.fin = (i == s.len() - 1);
            expected_bytes.push_back(b);
        end
    endfunction

    // Appends the escaped byte run of one code point under the given delimiter.
    function automatic void predict_escape(input logic [xae_pkg::CP_W-1:0] cp, input logic mode);
        xae_pkg::kind_t kind;
        if (cp == xae_pkg::CP_W'(xae_pkg::CH_LT))
            kind = xae_pkg::K_LT;
        else if (cp == xae_pkg::CP_W'(xae_pkg::CH_AMP))
            kind = xae_pkg::K_AMP;
        else if (cp == xae_pkg::CP_W'(xae_pkg::CH_QUOT) && mode == 1'b0)
            kind = xae_pkg::K_QUOT;
        else if (cp == xae_pkg::CP_W'(xae_pkg::CH_APOS) && mode == 1'b1)
            kind = xae_pkg::K_APOS;
        else if (cp >= xae_pkg::PRINT_LO && cp <= xae_pkg::PRINT_HI)
            kind = xae_pkg::K_PLAIN;
        else
            kind = xae_pkg::K_NUM;
        case (kind)
            xae_pkg::K_LT:    push_text("&lt;");
            xae_pkg::K_AMP:   push_text("&amp;");
            xae_pkg::K_QUOT:  push_text("&quot;");
            xae_pkg::K_APOS:  push_text("&apos;");
            xae_pkg::K_PLAIN: push_text($sformatf("%c", cp[7:0]));
            default:          push_text($sformatf("&#%0d;", cp));
        endcase
    endfunction

    function automatic logic [xae_pkg::CP_W-1:0] random_code_point();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return xae_pkg::CP_W'($urandom_range(xae_pkg::PRINT_HI, xae_pkg::PRINT_LO));
        if (pick < 55)
        begin
            case ($urandom_range(3))
                0:       return xae_pkg::CP_W'(xae_pkg::CH_LT);
                1:       return xae_pkg::CP_W'(xae_pkg::CH_AMP);
                2:       return xae_pkg::CP_W'(xae_pkg::CH_QUOT);
                default: return xae_pkg::CP_W'(xae_pkg::CH_APOS);
            endcase
        end
        if (pick < 65)
            return ($urandom_range(4) == 0) ? xae_pkg::CP_W'(127)
                                            : xae_pkg::CP_W'($urandom_range(xae_pkg::PRINT_LO - 1));
        if (pick < 75)
            return xae_pkg::CP_W'($urandom_range(65535, 128));
        return xae_pkg::CP_W'($urandom_range(32'h1FFFFF));
    endfunction

    // Receiver back-pressure.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Tracks the register, predicts each accepted request and checks each accepted byte.
    always @(posedge clk)
    begin : monitor
        esc_byte_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                model_quote_mode = cfg_wr_data;
            if (in_valid && !in_stall)
                predict_escape(code_point, model_quote_mode);
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected byte: expected none, actual out_char %h last %b",
                             $time, out_char, last);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_char !== want.ch)
                    begin
                        errors++;
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $time, want.ch, out_char);
                    end
                    if (last !== want.fin)
                    begin
                        errors++;
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.fin, last);
                    end
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_code_point(input logic [xae_pkg::CP_W-1:0] cp);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        code_point <= cp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_quote_mode(input logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic test_plain_and_named();
        send_code_point(xae_pkg::PRINT_LO);
        send_code_point(xae_pkg::PRINT_HI);
        send_code_point(xae_pkg::CP_W'(127));
        send_code_point(xae_pkg::PRINT_LO - 1);
        send_code_point(xae_pkg::CP_W'(0));
        send_code_point(xae_pkg::CP_W'(xae_pkg::CH_LT));
        send_code_point(xae_pkg::CP_W'(xae_pkg::CH_AMP));
        send_code_point(xae_pkg::CP_W'(xae_pkg::CH_QUOT));
        send_code_point(xae_pkg::CP_W'(xae_pkg::CH_APOS));
        send_code_point(xae_pkg::CP_W'(8'h41));
        wait_until_drained();
    endtask

    task automatic test_quote_selection();
        write_quote_mode(1'b1);
        send_code_point(xae_pkg::CP_W'(xae_pkg::CH_QUOT));
        send_code_point(xae_pkg::CP_W'(xae_pkg::CH_APOS));
        wait_until_drained();
        write_quote_mode(1'b0);
        send_code_point(xae_pkg::CP_W'(xae_pkg::CH_APOS));
        wait_until_drained();
    endtask

    task automatic test_decimal_refs();
        send_code_point(xae_pkg::CP_W'(1));
        send_code_point(xae_pkg::CP_W'(9));
        send_code_point(xae_pkg::CP_W'(10));
        send_code_point(xae_pkg::CP_W'(128));
        send_code_point(xae_pkg::CP_W'(999));
        send_code_point(xae_pkg::CP_W'(21'h00D800));
        send_code_point(xae_pkg::CP_W'(21'h00DFFF));
        send_code_point(xae_pkg::CP_W'(1114111));
        send_code_point(xae_pkg::CP_W'(1114112));
        send_code_point(xae_pkg::CP_W'(21'h1FFFFF));
        wait_until_drained();
    endtask

    task automatic test_random_stream(input int s_pct, input int r_pct, input logic mode,
                                      input int count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_quote_mode(mode);
        for (int i = 0; i < count; i++)
        begin
            send_code_point(random_code_point());
            // Now and then the sender holds off until the output has caught up.
            if ($urandom_range(39) == 0)
                wait_until_drained();
        end
        wait_until_drained();
    endtask

    initial
    begin
        send_idle_pct = 36;
        recv_idle_pct = 70;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_and_named();
        test_quote_selection();
        test_decimal_refs();
        test_random_stream(36, 70, 1'b1, 84);
        test_random_stream(70, 36, 1'b0, 83);
        test_random_stream(0, 0, 1'b1, 83);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
